FILE: src/istr_pkg.sv
package istr_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int TAG_W    = 16;
    localparam int KEY_W    = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;

    localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [TAG_W-1:0]    tag;
    } t_rec;

    typedef struct packed {
        logic ins;   // insert the broadcast word this cycle
        logic emit;  // shift the whole row one place towards cell 0
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    function automatic logic [KEY_W-1:0] rec_key(input t_rec r);
        rec_key = {r.year, r.month, r.day, r.hour, r.minute, r.second};
    endfunction

endpackage

FILE: src/istr_cell.sv
module istr_cell
    import istr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_rec      i_new,
    input  logic      i_prev_valid,
    input  logic      i_prev_greater,
    input  t_rec      i_prev_rec,
    input  logic      i_next_valid,
    input  t_rec      i_next_rec,
    output logic      o_valid,
    output logic      o_greater,
    output t_rec      o_rec
);

    logic r_valid;
    logic n_valid;
    t_rec r_rec;
    t_rec n_rec;

    // Stored key strictly above the new one: equal keys stay ahead (stable).
    assign o_greater = r_valid && (rec_key(r_rec) > rec_key(i_new));
    assign o_valid   = r_valid;
    assign o_rec     = r_rec;

    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ctl.emit) begin
            n_valid = i_next_valid;
            n_rec   = i_next_rec;
        end else if (i_ctl.ins) begin
            if (i_prev_greater) begin
                n_valid = 1'b1;
                n_rec   = i_prev_rec;
            end else if (o_greater || (!r_valid && i_prev_valid)) begin
                n_valid = 1'b1;
                n_rec   = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

FILE: src/insertion_sort_timestamp_records.sv
// Stable insertion sorter for timestamped records. A word is taken on any
// clock edge with start high and busy low, one per cycle, and is placed at
// once into a row of CAPACITY compare-and-shift cells, after every stored
// record with an equal or smaller key (year, month, day, hour, minute,
// second; a month above twelve counts as 0). Nothing comes out until a word
// with i_last set: from the next cycle the row shifts towards cell 0 and
// emits one record per cycle on o_strobe, holding busy high until the final
// record is out. Results are not held for the receiver: each is valid
// for exactly that one cycle and must be taken then. o_out_last marks the
// final record of the run. Words arriving with the row full are dropped and
// o_overflow is high on every record of that run.
module insertion_sort_timestamp_records
    import istr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [YEAR_W-1:0]   i_year,
    input  logic [MONTH_W-1:0]  i_month,
    input  logic [DAY_W-1:0]    i_day,
    input  logic [HOUR_W-1:0]   i_hour,
    input  logic [MINUTE_W-1:0] i_minute,
    input  logic [SECOND_W-1:0] i_second,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic                i_last,
    output logic                o_strobe,
    output logic [YEAR_W-1:0]   o_out_year,
    output logic [MONTH_W-1:0]  o_out_month,
    output logic [DAY_W-1:0]    o_out_day,
    output logic [HOUR_W-1:0]   o_out_hour,
    output logic [MINUTE_W-1:0] o_out_minute,
    output logic [SECOND_W-1:0] o_out_second,
    output logic [TAG_W-1:0]    o_out_tag,
    output logic                o_out_last,
    output logic                o_overflow
);

    t_state    r_state;
    t_state    n_state;
    logic      r_dropped;
    logic      n_dropped;
    logic      w_accept;
    logic      w_full;
    t_rec      w_new;
    t_cell_ctl w_ctl;

    logic      w_valid   [CAPACITY];
    logic      w_greater [CAPACITY];
    t_rec      w_rec     [CAPACITY];

    assign busy     = (r_state == ST_EMIT);
    assign w_accept = start && !busy;
    assign w_full   = w_valid[CAPACITY-1];

    always_comb begin
        w_new        = '0;
        w_new.year   = i_year;
        w_new.month  = (i_month > MONTH_MAX) ? '0 : i_month;
        w_new.day    = i_day;
        w_new.hour   = i_hour;
        w_new.minute = i_minute;
        w_new.second = i_second;
        w_new.tag    = i_tag;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic pv;
            logic pg;
            t_rec pr;
            logic nv;
            t_rec nr;
            if (gi == 0) begin : g_head
                assign pv = 1'b1;
                assign pg = 1'b0;
                assign pr = w_new;
            end else begin : g_mid
                assign pv = w_valid[gi-1];
                assign pg = w_greater[gi-1];
                assign pr = w_rec[gi-1];
            end
            if (gi == CAPACITY-1) begin : g_tail
                assign nv = 1'b0;
                assign nr = w_rec[gi];
            end else begin : g_body
                assign nv = w_valid[gi+1];
                assign nr = w_rec[gi+1];
            end
            istr_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (w_ctl),
                .i_new          (w_new),
                .i_prev_valid   (pv),
                .i_prev_greater (pg),
                .i_prev_rec     (pr),
                .i_next_valid   (nv),
                .i_next_rec     (nr),
                .o_valid        (w_valid[gi]),
                .o_greater      (w_greater[gi]),
                .o_rec          (w_rec[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_dropped  = r_dropped;
        w_ctl.ins  = 1'b0;
        w_ctl.emit = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        w_ctl.ins = 1'b1;
                    end
                    if (i_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                w_ctl.emit = 1'b1;
                if (!w_valid[1]) begin
                    n_state   = ST_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    // Cell 0 is always occupied while emitting; cell 1 empty marks the end.
    assign o_strobe     = busy;
    assign o_out_year   = w_rec[0].year;
    assign o_out_month  = w_rec[0].month;
    assign o_out_day    = w_rec[0].day;
    assign o_out_hour   = w_rec[0].hour;
    assign o_out_minute = w_rec[0].minute;
    assign o_out_second = w_rec[0].second;
    assign o_out_tag    = w_rec[0].tag;
    assign o_out_last   = busy && !w_valid[1];
    assign o_overflow   = r_dropped;

endmodule
